// ----- rtl/gaussian_weighted_grid_accumulator_assert.svh -----
// Assertion macros for the weighted grid accumulator.
`ifndef GAUSSIAN_WEIGHTED_GRID_ACCUMULATOR_ASSERT_SVH
`define GAUSSIAN_WEIGHTED_GRID_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define GWGA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GWGA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gwga_pkg.sv -----
// Shared types, constants and a table function for the weighted grid accumulator.
package gwga_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned DIV_W       = 48;
    localparam int unsigned DIVISOR_W   = 32;
    localparam int unsigned DIV10_MUL   = 52429;
    localparam int unsigned DIV10_SHIFT = 19;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RADIUS_SCALE   = 3'd0,
        CFG_MAX_DISTANCE   = 3'd1,
        CFG_MIN_WEIGHT_SUM = 3'd2,
        CFG_BAD_OBS_CODE   = 3'd3,
        CFG_BAD_DATA_CODE  = 3'd4
    } gwga_cfg_index_t;

    typedef enum logic [1:0] {
        OP_CLEAR      = 2'd0,
        OP_ACCUMULATE = 2'd1,
        OP_READOUT    = 2'd2,
        OP_UNUSED     = 2'd3
    } gwga_op_t;

    typedef struct packed {
        logic [15:0] radius_scale;
        logic [15:0] max_distance;
        logic [31:0] min_weight_sum;
        logic [23:0] bad_obs_code;
        logic [23:0] bad_data_code;
    } gwga_cfg_t;

    typedef struct packed {
        gwga_op_t    op;
        logic        in_grid;
        logic [15:0] cell_idx;
        logic [23:0] obs;
        logic [15:0] distance;
    } gwga_item_t;

    typedef struct packed {
        logic [15:0]        cnt;
        logic signed [47:0] vs;
        logic [31:0]        ws;
    } gwga_cell_t;

    typedef struct packed {
        logic busy;
        logic div_start;
        logic div_busy;
    } gwga_status_t;

    // table entry k: round(65536 * 0.1^(k / 2^bits)), evaluated at elaboration
    function automatic logic [16:0] wtab_entry(input int unsigned k, input int unsigned bits);
        logic [63:0] root;
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        int unsigned i;
        int unsigned j;
        root = 64'd429496730;
        for (i = 0; i < bits; i++)
        begin
            v   = root << 32;
            res = 64'd0;
            bt  = 64'd1 << 62;
            for (j = 0; j < 32; j++)
            begin
                if (v >= res + bt)
                begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end
                else
                begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            root = res;
        end
        p = 64'd1 << 32;
        for (i = 0; i < k; i++)
        begin
            p = (p * root) >> 32;
            if (p > (64'd1 << 32))
            begin
                p = 64'd1 << 32;
            end
        end
        return 17'((p + 64'h8000) >> 16);
    endfunction

endpackage

// ----- rtl/gaussian_weighted_grid_accumulator.sv -----
// Order from input transfer: clear writes the store; readout shows its result after a divide,
// or without one for an empty, light or out-of-grid cell; accumulate writes the store after a
// divide, the table interpolation and up to four divide-by-ten steps for the weight. The
// bit-serial divider makes one pass per accumulate and per readout of a valid cell. The back
// end takes one item at a time; a two-entry queue keeps input transfers going while it works. Reset is
// asynchronous, active low, clears control and config; cell contents stay undefined.
module gaussian_weighted_grid_accumulator
    import gwga_pkg::*;
#(
    parameter int unsigned GRID_CELLS        = 65536,
    parameter int unsigned WEIGHT_TABLE_BITS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,   // cell_index, obs_sample, distance, distance overflow bit, zero pad
    input  logic [1:0]             s_tuser,   // operation
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [39:0]            m_tdata,   // analysed_value, result_cell
    output logic [0:0]             m_tuser,   // value_valid
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    `include "gaussian_weighted_grid_accumulator_assert.svh"

    gwga_cfg_t    cfg_reg, cfg_next;
    logic         q_valid;
    logic         q_ready;
    gwga_item_t   q_item;
    gwga_status_t status;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (gwga_cfg_index_t'(cfg_index))
                CFG_RADIUS_SCALE:   cfg_next.radius_scale   = cfg_data[15:0];
                CFG_MAX_DISTANCE:   cfg_next.max_distance   = cfg_data[15:0];
                CFG_MIN_WEIGHT_SUM: cfg_next.min_weight_sum = cfg_data;
                CFG_BAD_OBS_CODE:   cfg_next.bad_obs_code   = cfg_data[23:0];
                CFG_BAD_DATA_CODE:  cfg_next.bad_data_code  = cfg_data[23:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius_scale   <= 16'd16;
            cfg_reg.max_distance   <= 16'hFFFF;
            cfg_reg.min_weight_sum <= 32'd0;
            cfg_reg.bad_obs_code   <= 24'h800000;
            cfg_reg.bad_data_code  <= 24'h800000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gwga_front #(
        .GRID_CELLS (GRID_CELLS)
    ) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    gwga_back #(
        .GRID_CELLS        (GRID_CELLS),
        .WEIGHT_TABLE_BITS (WEIGHT_TABLE_BITS)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .status   (status)
    );

    `GWGA_ASSERT_IMP(a_div_only_when_busy, status.div_busy, status.busy, "divider runs while back end idle")
    `GWGA_ASSERT_IMP(a_result_only_when_busy, m_tvalid, status.busy, "result shown while back end idle")
    `GWGA_ASSERT_NXT(a_div_starts, status.div_start, status.div_busy, "divider did not start")

endmodule

// ----- rtl/gwga_front.sv -----
// Front end: accepts items, drops the ignored ones and queues the rest.
module gwga_front
    import gwga_pkg::*;
#(
    parameter int unsigned GRID_CELLS = 65536
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  gwga_cfg_t  cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0] s_tuser,
    output logic       q_valid,
    input  logic       q_ready,
    output gwga_item_t q_item
);

    gwga_item_t   fifo_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    gwga_item_t   item;
    logic         keep;
    logic         push;
    logic         pop;

    always_comb
    begin
        item.op       = gwga_op_t'(s_tuser);
        item.cell_idx = s_tdata[15:0];
        item.obs      = s_tdata[39:16];
        item.distance = s_tdata[55:40];
        item.in_grid  = {5'd0, s_tdata[15:0]} < 21'(GRID_CELLS);
        unique case (item.op)
            OP_CLEAR:      keep = item.in_grid;
            OP_ACCUMULATE: keep = item.in_grid && (item.obs != cfg.bad_obs_code) &&
                                  !s_tdata[56] && (item.distance <= cfg.max_distance);
            OP_READOUT:    keep = 1'b1;
            default:       keep = 1'b0;
        endcase
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ----- rtl/gwga_div.sv -----
// Restoring divider, one quotient bit per cycle.
module gwga_div
    import gwga_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 busy,
    output logic                 done,
    output logic [DIV_W-1:0]     quotient
);

    localparam int unsigned CNT_W = $clog2(DIV_W);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIVISOR_W:0]   rem_shift;
    logic                 ge;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        ge        = rem_shift >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIVISOR_W'(rem_shift - {1'b0, dvs_reg}) : rem_shift[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_next;

endmodule

// ----- rtl/gwga_back.sv -----
// Back end: cell store and clear, weight computation, accumulation and readout.
module gwga_back
    import gwga_pkg::*;
#(
    parameter int unsigned GRID_CELLS        = 65536,
    parameter int unsigned WEIGHT_TABLE_BITS = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  gwga_cfg_t    cfg,
    input  logic         q_valid,
    output logic         q_ready,
    input  gwga_item_t   q_item,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,
    output logic [0:0]   m_tuser,
    output gwga_status_t status
);

    localparam int unsigned AW      = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int unsigned B       = WEIGHT_TABLE_BITS;
    localparam int unsigned FS      = 16 - B;
    localparam int unsigned TBL_LEN = (1 << B) + 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CLEAR  = 11'b000_0000_0010,
        S_READ   = 11'b000_0000_0100,
        S_LOOK   = 11'b000_0000_1000,
        S_XWAIT  = 11'b000_0001_0000,
        S_INTERP = 11'b000_0010_0000,
        S_TSTART = 11'b000_0100_0000,
        S_SCALE  = 11'b000_1000_0000,
        S_MUL    = 11'b001_0000_0000,
        S_WRITE  = 11'b010_0000_0000,
        S_QWAIT  = 11'b100_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    gwga_item_t        item_reg;
    gwga_cell_t        mem [GRID_CELLS];
    gwga_cell_t        rdata_reg;
    gwga_cell_t        wdata;
    logic              mem_we;
    logic [AW-1:0]     addr;
    logic [16:0]       wtab [TBL_LEN];
    logic [DIV_W-1:0]  x_reg;
    logic [16:0]       wraw_reg;
    logic [2:0]        n_reg;
    logic [15:0]       w_reg;
    logic signed [40:0] prod_reg;
    logic              neg_reg;
    logic [23:0]       out_value_reg;
    logic              out_ok_reg;
    logic [15:0]       out_cell_reg;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic              div_busy;
    logic              div_done;
    logic [DIV_W-1:0]  div_q;

    logic              ok;
    logic [47:0]       vs_mag;
    logic [B-1:0]      tk;
    logic [B:0]        tk1;
    logic [FS-1:0]     tr;
    logic [16:0]       t0, t1;
    logic [16+FS:0]    dprod;
    logic [16:0]       wraw;
    logic              wzero;
    logic [32:0]       d10_prod;
    logic [16:0]       d10;
    logic [32:0]       ws_sum;
    logic signed [48:0] vs_sum;
    logic [23:0]       q_sat;

    for (genvar g = 0; g < TBL_LEN; g++)
    begin : g_wtab
        localparam logic [16:0] ENTRY = wtab_entry(g, B);
        assign wtab[g] = ENTRY;
    end

    gwga_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign addr = AW'(item_reg.cell_idx);

    always_comb
    begin
        ok = item_reg.in_grid && (rdata_reg.cnt != 16'd0) && (rdata_reg.ws != 32'd0) &&
             (rdata_reg.ws >= cfg.min_weight_sum);
        vs_mag = rdata_reg.vs[47] ? 48'(-rdata_reg.vs) : rdata_reg.vs;
        tk     = x_reg[15:FS];
        tk1    = {1'b0, tk} + 1'b1;
        tr     = x_reg[FS-1:0];
        t0     = wtab[tk];
        t1     = wtab[tk1];
        dprod  = (t0 - t1) * tr;
        wraw   = t0 - 17'(dprod >> FS);
        wzero  = (|x_reg[47:19]) || (x_reg[18:16] > 3'd4);
        d10_prod = {16'd0, wraw_reg} * 33'(DIV10_MUL);
        d10      = 17'(d10_prod >> DIV10_SHIFT);
        ws_sum = {1'b0, rdata_reg.ws} + {17'd0, w_reg};
        vs_sum = {rdata_reg.vs[47], rdata_reg.vs} + 49'(prod_reg);
        if (neg_reg)
        begin
            q_sat = (div_q > 48'd8388608) ? 24'h800000 : 24'(-div_q);
        end
        else
        begin
            q_sat = (div_q > 48'd8388607) ? 24'h7FFFFF : div_q[23:0];
        end
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {16'd0, item_reg.distance, 16'd0};
        div_divisor  = {16'd0, (cfg.radius_scale == 16'd0) ? 16'd1 : cfg.radius_scale};
        mem_we       = 1'b0;
        wdata        = '0;
        q_ready      = 1'b0;
        state_next   = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                q_ready = !out_valid_reg;
                if (q_valid && !out_valid_reg)
                begin
                    state_next = (q_item.op == OP_CLEAR) ? S_CLEAR : S_READ;
                end
            end
            S_CLEAR:
            begin
                mem_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (item_reg.op == OP_ACCUMULATE)
                begin
                    div_start  = 1'b1;
                    state_next = S_XWAIT;
                end
                else if (ok)
                begin
                    div_start    = 1'b1;
                    div_dividend = vs_mag;
                    div_divisor  = rdata_reg.ws;
                    state_next   = S_QWAIT;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_XWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_INTERP;
                end
            end
            S_INTERP:
            begin
                state_next = S_TSTART;
            end
            S_TSTART:
            begin
                state_next = wzero ? S_MUL : S_SCALE;
            end
            S_SCALE:
            begin
                if (n_reg == 3'd0)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                mem_we   = 1'b1;
                wdata.ws = ws_sum[32] ? 32'hFFFF_FFFF : ws_sum[31:0];
                if (vs_sum[48] != vs_sum[47])
                begin
                    wdata.vs = vs_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                end
                else
                begin
                    wdata.vs = vs_sum[47:0];
                end
                wdata.cnt  = (rdata_reg.cnt == 16'hFFFF) ? 16'hFFFF : rdata_reg.cnt + 1'b1;
                state_next = S_IDLE;
            end
            S_QWAIT:
            begin
                if (div_done)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_ready && q_valid)
        begin
            item_reg <= q_item;
        end
        if (state_reg == S_READ)
        begin
            rdata_reg <= mem[addr];
        end
        if (mem_we)
        begin
            mem[addr] <= wdata;
        end
        if (state_reg == S_LOOK)
        begin
            neg_reg       <= rdata_reg.vs[47];
            out_cell_reg  <= item_reg.cell_idx;
            out_ok_reg    <= 1'b0;
            out_value_reg <= cfg.bad_data_code;
        end
        if (state_reg == S_XWAIT && div_done)
        begin
            x_reg <= div_q;
        end
        if (state_reg == S_INTERP)
        begin
            wraw_reg <= wraw;
            n_reg    <= x_reg[18:16];
        end
        if (state_reg == S_TSTART && wzero)
        begin
            w_reg <= 16'd0;
        end
        if (state_reg == S_SCALE)
        begin
            if (n_reg == 3'd0)
            begin
                w_reg <= wraw_reg[16] ? 16'hFFFF : wraw_reg[15:0];
            end
            else
            begin
                wraw_reg <= d10;
                n_reg    <= n_reg - 1'b1;
            end
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= $signed(item_reg.obs) * $signed({1'b0, w_reg});
        end
        if (state_reg == S_QWAIT && div_done)
        begin
            out_ok_reg    <= 1'b1;
            out_value_reg <= q_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_cell_reg, out_value_reg};
    assign m_tuser  = out_ok_reg;

    assign status.busy      = (state_reg != S_IDLE) || out_valid_reg;
    assign status.div_start = div_start;
    assign status.div_busy  = div_busy;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the weighted grid accumulator: directed and random streams against a predictor.
`timescale 1ns / 100ps

class grid_scoreboard;
    typedef struct {
        logic [23:0] value;
        logic        valid;
        logic [15:0] cell_id;
    } readout_t;

    bit [31:0]   weight_tab[257];
    bit [15:0]   radius_scale;
    bit [15:0]   max_distance;
    bit [31:0]   min_weight_sum;
    bit [23:0]   bad_obs_code;
    bit [23:0]   bad_data_code;
    bit [31:0]   wsum[int];
    longint      vsum[int];
    int          count[int];
    readout_t    pending[$];
    int          errors;

    function new();
        bit [63:0] root;
        bit [63:0] prod;
        errors = 0;
        set_defaults();
        root = 64'd429496730;
        for (int i = 0; i < 8; i++)
        begin
            root = int_sqrt(root << 32);
        end
        prod = 64'd1 << 32;
        for (int i = 0; i < 257; i++)
        begin
            weight_tab[i] = 32'((prod + 64'h8000) >> 16);
            prod = (prod * root) >> 32;
            if (prod > (64'd1 << 32))
            begin
                prod = 64'd1 << 32;
            end
        end
    endfunction

    function void set_defaults();
        radius_scale   = 16'd16;
        max_distance   = 16'hFFFF;
        min_weight_sum = 32'd0;
        bad_obs_code   = 24'h800000;
        bad_data_code  = 24'h800000;
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function void set_reg(gwga_pkg::gwga_cfg_index_t idx, bit [31:0] data);
        case (idx)
            gwga_pkg::CFG_RADIUS_SCALE:   radius_scale = data[15:0];
            gwga_pkg::CFG_MAX_DISTANCE:   max_distance = data[15:0];
            gwga_pkg::CFG_MIN_WEIGHT_SUM: min_weight_sum = data;
            gwga_pkg::CFG_BAD_OBS_CODE:   bad_obs_code = data[23:0];
            gwga_pkg::CFG_BAD_DATA_CODE:  bad_data_code = data[23:0];
            default: ;
        endcase
    endfunction

    function bit [31:0] obs_weight(bit [15:0] d);
        bit [63:0] x;
        bit [63:0] whole;
        bit [31:0] frac;
        bit [31:0] k;
        bit [31:0] r;
        bit [31:0] w;
        bit [31:0] scale;
        scale = (radius_scale == 0) ? 32'd1 : 32'(radius_scale);
        x = (64'(d) << 16) / scale;
        whole = x >> 16;
        if (whole >= 5)
        begin
            return 0;
        end
        frac = 32'(x[15:0]);
        k = frac >> 8;
        r = frac & 32'hFF;
        w = weight_tab[k] - (((weight_tab[k] - weight_tab[k + 1]) * r) >> 8);
        for (int i = 0; i < whole; i++)
        begin
            w = w / 10;
        end
        return (w > 65535) ? 32'd65535 : w;
    endfunction

    function void note_item(gwga_pkg::gwga_op_t op, bit [15:0] cell_id, bit [23:0] obs,
                            bit [16:0] dist_val);
        bit [32:0] ws;
        longint    vs;
        bit [31:0] w;
        readout_t  rd;
        longint    q;
        case (op)
            gwga_pkg::OP_CLEAR:
            begin
                wsum[cell_id] = 0;
                vsum[cell_id] = 0;
                count[cell_id] = 0;
            end
            gwga_pkg::OP_ACCUMULATE:
            begin
                if (obs != bad_obs_code && !dist_val[16] && dist_val[15:0] <= max_distance)
                begin
                    w = obs_weight(dist_val[15:0]);
                    ws = 33'(wsum[cell_id]) + 33'(w);
                    wsum[cell_id] = ws[32] ? 32'hFFFFFFFF : ws[31:0];
                    vs = vsum[cell_id] + longint'($signed(obs)) * longint'(w);
                    if (vs > 64'sh7FFF_FFFF_FFFF)
                    begin
                        vs = 64'sh7FFF_FFFF_FFFF;
                    end
                    if (vs < -64'sh8000_0000_0000)
                    begin
                        vs = -64'sh8000_0000_0000;
                    end
                    vsum[cell_id] = vs;
                    if (count[cell_id] != 65535)
                    begin
                        count[cell_id]++;
                    end
                end
            end
            gwga_pkg::OP_READOUT:
            begin
                rd.cell_id = cell_id;
                rd.valid = count[cell_id] != 0 && wsum[cell_id] != 0 &&
                           wsum[cell_id] >= min_weight_sum;
                rd.value = bad_data_code;
                if (rd.valid)
                begin
                    q = vsum[cell_id] / longint'(wsum[cell_id]);
                    if (q > 8388607)
                    begin
                        q = 8388607;
                    end
                    if (q < -8388608)
                    begin
                        q = -8388608;
                    end
                    rd.value = q[23:0];
                end
                pending = {pending, rd};
            end
            default: ;
        endcase
    endfunction

    function void check_result(bit [23:0] value, bit valid, bit [15:0] cell_id);
        readout_t rd;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected readout value=%h valid=%b cell=%h", $time, value, valid,
                     cell_id);
            errors++;
            return;
        end
        rd = pending.pop_front();
        if (rd.value !== value)
        begin
            $display("%0t: analysed_value expected %h actual %h", $time, rd.value, value);
            errors++;
        end
        if (rd.valid !== valid)
        begin
            $display("%0t: value_valid expected %b actual %b", $time, rd.valid, valid);
            errors++;
        end
        if (rd.cell_id !== cell_id)
        begin
            $display("%0t: result_cell expected %h actual %h", $time, rd.cell_id, cell_id);
            errors++;
        end
    endfunction
endclass

module testbench;
    import gwga_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    grid_scoreboard sb;
    int             cycles;
    bit             steady;
    bit [15:0]      cell_pool[$];

    gaussian_weighted_grid_accumulator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (steady)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 94)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata[23:0], m_tuser[0], m_tdata[39:24]);
        end
    end

    initial
    begin
        int stall;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // called at a falling edge; returns at a falling edge after the transfer
    task automatic send_item(gwga_op_t op, bit [15:0] cell_id, bit [23:0] obs,
                             bit [16:0] dist_val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {7'd0, dist_val, obs, cell_id};
        s_tuser  = op;
        s_tvalid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_item(op, cell_id, obs, dist_val);
        @(negedge clk);
    endtask

    task automatic write_reg(gwga_cfg_index_t idx, bit [31:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_all(bit [15:0] rs, bit [15:0] md, bit [31:0] mw, bit [23:0] bo,
                             bit [23:0] bd);
        write_reg(CFG_RADIUS_SCALE, {16'd0, rs});
        write_reg(CFG_MAX_DISTANCE, {16'd0, md});
        write_reg(CFG_MIN_WEIGHT_SUM, mw);
        write_reg(CFG_BAD_OBS_CODE, {8'd0, bo});
        write_reg(CFG_BAD_DATA_CODE, {8'd0, bd});
    endtask

    task automatic random_phase(int count);
        int        roll;
        bit [15:0] cell_id;
        bit [23:0] obs;
        bit [16:0] dist_val;
        int        span;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                steady = ~steady;
            end
            roll = $urandom_range(0, 99);
            cell_id = cell_pool[$urandom_range(0, cell_pool.size() - 1)];
            obs  = 24'($urandom());
            if ($urandom_range(0, 3) == 0)
            begin
                obs = {{12{obs[23]}}, obs[11:0]};
            end
            span = (sb.radius_scale == 0 ? 1 : sb.radius_scale) * 6;
            dist_val = (span > 65535) ? 17'($urandom_range(0, 65535)) :
                                        17'($urandom_range(0, span));
            if ($urandom_range(0, 15) == 0)
            begin
                dist_val = 17'($urandom());
            end
            if ($urandom_range(0, 19) == 0)
            begin
                obs = sb.bad_obs_code;
            end
            if (roll < 60)
            begin
                send_item(OP_ACCUMULATE, cell_id, obs, dist_val);
            end
            else if (roll < 88)
            begin
                send_item(OP_READOUT, cell_id, obs, dist_val);
            end
            else if (roll < 96)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    cell_id = 16'($urandom());
                    if (cell_pool.size() < 40)
                    begin
                        cell_pool = {cell_pool, cell_id};
                    end
                end
                send_item(OP_CLEAR, cell_id, obs, dist_val);
            end
            else
            begin
                send_item(OP_UNUSED, 16'($urandom()), obs, dist_val);
            end
        end
    endtask

    initial
    begin
        sb        = new();
        cycles    = 0;
        steady    = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_CLEAR;
        cfg_valid = 1'b0;
        cfg_index = CFG_RADIUS_SCALE;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cell_pool = {cell_pool, 16'h0000};
        cell_pool = {cell_pool, 16'hFFFF};
        for (int i = 0; i < 6; i++)
        begin
            cell_pool = {cell_pool, 16'($urandom())};
        end
        foreach (cell_pool[i])
        begin
            send_item(OP_CLEAR, cell_pool[i], 24'h0, 17'h0);
        end

        // empty cell, distance and sample extremes, missing observation, unused operation
        send_item(OP_READOUT, 16'h0000, 24'h0, 17'h0);
        send_item(OP_ACCUMULATE, 16'h0000, 24'h7FFFFF, 17'h00000);
        send_item(OP_ACCUMULATE, 16'h0000, 24'h800001, 17'h0FFFF);
        send_item(OP_ACCUMULATE, 16'h0000, 24'h000100, 17'h1FFFF);
        send_item(OP_ACCUMULATE, 16'h0000, 24'h000100, 17'h10000);
        send_item(OP_ACCUMULATE, 16'h0000, 24'h800000, 17'h00010);
        send_item(OP_READOUT, 16'h0000, 24'h0, 17'h0);
        send_item(OP_ACCUMULATE, 16'hFFFF, 24'h800001, 17'h00008);
        send_item(OP_ACCUMULATE, 16'hFFFF, 24'hFFFFFF, 17'h00050);
        send_item(OP_READOUT, 16'hFFFF, 24'h0, 17'h0);
        send_item(OP_UNUSED, 16'h1234, 24'h0, 17'h0);
        random_phase(250);

        wait_idle();
        write_all(16'd0, 16'd40, 32'd0, 24'h7FFFFF, 24'h7FFFFF);
        send_item(OP_ACCUMULATE, 16'h0000, 24'h7FFFFF, 17'h00005);
        send_item(OP_ACCUMULATE, 16'h0000, 24'h000200, 17'h00029);
        send_item(OP_READOUT, 16'h0000, 24'h0, 17'h0);
        random_phase(250);

        wait_idle();
        write_all(16'hFFFF, 16'd0, 32'hFFFFFFFF, 24'h000000, 24'h000000);
        random_phase(250);

        wait_idle();
        write_all(16'd1, 16'hFFFF, 32'd70000, 24'h123456, 24'h800000);
        random_phase(300);

        wait_idle();
        write_all(16'd64, 16'd2000, 32'd1, 24'hFFFFFF, 24'h0ABCDE);
        random_phase(300);

        wait_idle();
        write_all(16'd300, 16'hFFFF, 32'd20000, 24'h800000, 24'h7FFFFF);
        random_phase(330);

        wait_idle();
        if (sb.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/gwga_pkg.sv
rtl/gwga_front.sv
rtl/gwga_div.sv
rtl/gwga_back.sv
rtl/gaussian_weighted_grid_accumulator.sv
tb/sv/testbench.sv
